// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros, sampled on the rising edge of clk and off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every enabled edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/bse_pkg.sv =====
package bse_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int BIT_IDX_W  = 12;
  localparam int BYTE_IDX_W = 9;
  localparam int BYTE_CNT_W = 4;
  localparam int BIT_CNT_W  = 7;
  localparam int SIZE_W     = 13;
  localparam int DATA_W     = 8;
  localparam int FILLED_W   = 4;

  // byte address register, wide enough for a run that steps past the store
  localparam int ADDR_W = BYTE_IDX_W + 1;

  localparam int STORE_BITS_DEF = 4096;
  localparam int MAX_RUN_BYTES  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_SET,
    OP_CLEAR,
    OP_WRITE,
    OP_TEST,
    OP_TAS,
    OP_READ,
    OP_READ_NEG,
    OP_EXTRACT
  } bse_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_BIT_MOD,
    ST_RUN_RD,
    ST_RUN_OUT,
    ST_X_NEXT,
    ST_X_OUT,
    ST_EMPTY
  } bse_state_t;

  // controller to datapath
  typedef struct packed {
    logic ready;
    logic rd_en;
    logic adv;
    logic prev_ld;
    logic bit_wr;
    logic emit;
    logic emit_empty;
    logic clr_start;
    logic clr_wr;
  } bse_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accepted;
    logic bit_op;
    logic extract;
    logic empty;
    logic last_byte;
    logic out_free;
    logic clr_done;
  } bse_status_t;

endpackage

// ===== hw/rtl/bse_in_if.sv =====
interface bse_in_if import bse_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [BIT_IDX_W-1:0]  bit_index;
  logic                  bit_value;
  logic [BYTE_IDX_W-1:0] byte_index;
  logic [BYTE_CNT_W-1:0] byte_count;
  logic [BIT_CNT_W-1:0]  bit_count;

  modport source (
    output valid, op, bit_index, bit_value, byte_index, byte_count, bit_count,
    input  ready
  );

  modport sink (
    input  valid, op, bit_index, bit_value, byte_index, byte_count, bit_count,
    output ready
  );
endinterface

// ===== hw/rtl/bse_out_if.sv =====
interface bse_out_if import bse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_byte;
  logic                flag;
  logic [FILLED_W-1:0] bytes_filled;
  logic                last;

  modport source (
    output valid, data_byte, flag, bytes_filled, last,
    input  ready
  );

  modport sink (
    input  valid, data_byte, flag, bytes_filled, last,
    output ready
  );
endinterface

// ===== hw/rtl/bse_datapath.sv =====
`include "assert_macros.svh"

module bse_datapath import bse_pkg::*; #(
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  bse_in_if.sink            item,
  bse_out_if.source         result,
  input  bse_cmd_t          cmd,
  output bse_status_t       st
);

  localparam int STORE_BYTES = (STORE_BITS + 7) / 8;
  localparam int MW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int SIZE_MAX    = (1 << SIZE_W) - 1;
  localparam int SIZE_RST    = (STORE_BITS > SIZE_MAX) ? SIZE_MAX : STORE_BITS;
  localparam int CAP_W       = SIZE_W - 2;
  localparam logic [BYTE_CNT_W-1:0] MAX_CNT  = BYTE_CNT_W'(MAX_RUN_BYTES);
  localparam logic [BIT_CNT_W-1:0]  MAX_BITS = BIT_CNT_W'(MAX_RUN_BYTES * 8);

  logic [SIZE_W-1:0]    size;
  logic [DATA_W-1:0]    mem [STORE_BYTES];
  logic [MW-1:0]        clr_addr;
  logic                 clr_done;

  // item held while it runs
  bse_op_t              op;
  logic                 bval;
  logic [2:0]           pos;
  logic                 in_range;
  logic [ADDR_W-1:0]    addr;
  logic [FILLED_W-1:0]  n_q;
  logic [FILLED_W-1:0]  cnt;
  logic [BIT_CNT_W-1:0] bits_q;
  logic [DATA_W-1:0]    rd_q;
  logic [DATA_W-1:0]    prev;

  // output register
  logic                 out_valid;
  logic [DATA_W-1:0]    out_data;
  logic                 out_flag;
  logic [FILLED_W-1:0]  out_filled;
  logic                 out_last;
  logic                 out_free;

  // decode at accept
  logic                 load;
  bse_op_t              op_in;
  logic                 is_run;
  logic [CAP_W-1:0]     cap;
  logic [CAP_W-1:0]     run_room;
  logic [BYTE_CNT_W-1:0] want_b;
  logic [BYTE_CNT_W-1:0] run_n;
  logic                 hit;
  logic [SIZE_W-1:0]    x_room;
  logic [BIT_CNT_W-1:0] want_x;
  logic [BIT_CNT_W-1:0] x_bits;
  logic [FILLED_W-1:0]  x_n;

  // per-word datapath
  logic                 in_mem;
  logic [MW-1:0]        mem_idx;
  logic                 bit_op;
  logic [DATA_W-1:0]    bit_mask;
  logic                 cur;
  logic [DATA_W-1:0]    new_byte;
  logic                 bit_flag;
  logic                 bit_wr_en;
  logic [2*DATA_W-1:0]  pair;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    x_mask;
  logic [DATA_W-1:0]    x_byte;
  logic [DATA_W-1:0]    run_byte;
  logic                 last_byte;

  assign item.ready = cmd.ready;
  assign load       = item.valid && cmd.ready;
  assign op_in      = bse_op_t'(item.op);
  assign is_run     = (op_in == OP_READ) || (op_in == OP_READ_NEG);

  // byte run clipping
  assign cap      = CAP_W'(({1'b0, size} + (SIZE_W + 1)'(7)) >> 3);
  assign run_room = cap - CAP_W'(item.byte_index);
  assign want_b   = (item.byte_count > MAX_CNT) ? MAX_CNT : item.byte_count;
  always_comb begin
    run_n = '0;
    if (CAP_W'(item.byte_index) < cap) begin
      run_n = (run_room > CAP_W'(want_b)) ? want_b : run_room[BYTE_CNT_W-1:0];
    end
  end

  // bit run clipping
  assign hit    = SIZE_W'(item.bit_index) < size;
  assign x_room = size - SIZE_W'(item.bit_index);
  assign want_x = (item.bit_count > MAX_BITS) ? MAX_BITS : item.bit_count;
  always_comb begin
    x_bits = '0;
    if (hit) begin
      x_bits = (x_room > SIZE_W'(want_x)) ? want_x : x_room[BIT_CNT_W-1:0];
    end
  end
  assign x_n = FILLED_W'(({1'b0, x_bits} + (BIT_CNT_W + 1)'(7)) >> 3);

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_W'(SIZE_RST);
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > STORE_BITS) begin
        size <= SIZE_W'(SIZE_RST);
      end else begin
        size <= cfg_wdata;
      end
    end
  end

  // item registers and run counters
  always_ff @(posedge clk) begin
    if (load) begin
      op       <= op_in;
      bval     <= item.bit_value;
      pos      <= item.bit_index[2:0];
      in_range <= hit;
      addr     <= is_run ? ADDR_W'(item.byte_index)
                         : ADDR_W'(item.bit_index[BIT_IDX_W-1:3]);
      n_q      <= (op_in == OP_EXTRACT) ? x_n : FILLED_W'(run_n);
      bits_q   <= x_bits;
      cnt      <= '0;
    end else begin
      if (cmd.adv) begin
        addr <= addr + ADDR_W'(1);
      end
      if (cmd.emit) begin
        cnt <= cnt + FILLED_W'(1);
      end
    end
  end

  // clearing pass counter
  assign clr_done = clr_addr == MW'(STORE_BYTES - 1);
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr && !clr_done) begin
      clr_addr <= clr_addr + MW'(1);
    end
  end

  assign in_mem  = 32'(addr) < STORE_BYTES;
  assign mem_idx = MW'(addr);

  // bit read-modify-write
  assign bit_op   = op <= OP_TAS;
  assign bit_mask = DATA_W'(1) << pos;
  assign cur      = rd_q[pos];
  always_comb begin
    case (op)
      OP_SET:   new_byte = rd_q | bit_mask;
      OP_CLEAR: new_byte = rd_q & ~bit_mask;
      OP_WRITE: new_byte = bval ? (rd_q | bit_mask) : (rd_q & ~bit_mask);
      OP_TAS:   new_byte = rd_q | bit_mask;
      default:  new_byte = rd_q;
    endcase
  end
  assign bit_flag  = in_range && (((op == OP_TEST) && cur) || ((op == OP_TAS) && !cur));
  assign bit_wr_en = cmd.bit_wr && in_range && in_mem && (op != OP_TEST);

  // byte store, one port
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= '0;
    end else if (bit_wr_en) begin
      mem[mem_idx] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q <= in_mem ? mem[mem_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prev_ld) begin
      prev <= rd_q;
    end
  end

  // unaligned extract: two neighbor bytes shifted down, negated, tail masked
  assign pair   = {rd_q, prev} >> pos;
  assign rem    = DATA_W'(bits_q) - {1'b0, cnt, 3'b000};
  assign x_mask = (rem >= DATA_W'(8)) ? '1 : (DATA_W'('1) >> (~rem[2:0] + 3'd1));
  assign x_byte = ~pair[DATA_W-1:0] & x_mask;

  assign run_byte  = (op == OP_READ_NEG) ? ~rd_q : rd_q;
  assign last_byte = (cnt + FILLED_W'(1)) == n_q;

  // output register
  assign out_free = !out_valid || result.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_empty) begin
        out_data   <= '0;
        out_flag   <= 1'b0;
        out_filled <= '0;
        out_last   <= 1'b1;
      end else if (bit_op) begin
        out_data   <= '0;
        out_flag   <= bit_flag;
        out_filled <= '0;
        out_last   <= 1'b1;
      end else begin
        out_data   <= (op == OP_EXTRACT) ? x_byte : run_byte;
        out_flag   <= 1'b0;
        out_filled <= n_q;
        out_last   <= last_byte;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.data_byte    = out_data;
  assign result.flag         = out_flag;
  assign result.bytes_filled = out_filled;
  assign result.last         = out_last;

  // status back to the controller
  assign st.accepted  = load;
  assign st.bit_op    = bit_op;
  assign st.extract   = op == OP_EXTRACT;
  assign st.empty     = n_q == '0;
  assign st.last_byte = last_byte;
  assign st.out_free  = out_free;
  assign st.clr_done  = clr_done;

  `ASSERT_CLK(a_emit_free, cmd.emit |-> out_free, "word loaded over an untaken result")
  `ASSERT_CLK(a_emit_cnt, cmd.emit && !cmd.emit_empty && !bit_op |-> cnt < n_q, "run overran count")
  `ASSERT_NEVER(a_wr_excl, cmd.clr_wr && bit_wr_en, "clear and bit write in one cycle")

endmodule

// ===== hw/rtl/bse_ctrl.sv =====
`include "assert_macros.svh"

module bse_ctrl import bse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  bse_status_t st,
  output bse_cmd_t    cmd
);

  bse_state_t state;
  bse_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (st.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (st.accepted) state_next = ST_START;
      end
      ST_START: begin
        if (st.bit_op) state_next = ST_BIT_MOD;
        else if (st.empty) state_next = ST_EMPTY;
        else if (st.extract) state_next = ST_X_NEXT;
        else state_next = ST_RUN_OUT;
      end
      ST_BIT_MOD: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_RUN_RD: begin
        state_next = ST_RUN_OUT;
      end
      ST_RUN_OUT: begin
        if (st.out_free) state_next = st.last_byte ? ST_IDLE : ST_RUN_RD;
      end
      ST_X_NEXT: begin
        state_next = ST_X_OUT;
      end
      ST_X_OUT: begin
        if (st.out_free) state_next = st.last_byte ? ST_IDLE : ST_X_NEXT;
      end
      ST_EMPTY: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a size write restarts the clearing pass
    if (cfg_we) state_next = ST_CLEAR;
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.clr_start = cfg_we;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = !cfg_we;
      end
      ST_IDLE: begin
        cmd.ready = !cfg_we;
      end
      ST_START: begin
        cmd.rd_en = !st.bit_op && st.empty ? 1'b0 : 1'b1;
        cmd.adv   = !st.bit_op && !st.empty;
      end
      ST_BIT_MOD: begin
        cmd.bit_wr = st.out_free;
        cmd.emit   = st.out_free;
      end
      ST_RUN_RD: begin
        cmd.rd_en = 1'b1;
        cmd.adv   = 1'b1;
      end
      ST_RUN_OUT: begin
        cmd.emit = st.out_free;
      end
      ST_X_NEXT: begin
        cmd.rd_en   = 1'b1;
        cmd.adv     = 1'b1;
        cmd.prev_ld = 1'b1;
      end
      ST_X_OUT: begin
        cmd.emit = st.out_free;
      end
      ST_EMPTY: begin
        cmd.emit       = st.out_free;
        cmd.emit_empty = st.out_free;
      end
      default: begin
        cmd.clr_wr = 1'b0;
      end
    endcase
  end

  `ASSERT_CLK(a_cfg_blocks, cfg_we |=> !cmd.ready, "item taken during clearing pass")
  `ASSERT_CLK(a_one_item, st.accepted |=> !cmd.ready, "second item taken while busy")

endmodule

// ===== hw/rtl/bitmap_store_engine_unit.sv =====
// bit ops and empty runs give one word each; a bit op word follows its store read
// byte runs: each byte is read, then emitted (single-port byte store), and a word
// waits while the last result is not taken; extracts read one byte ahead of the
// word they emit; no new item is taken until the last word of an item is emitted
// rst (and every size write) starts a clearing pass over all STORE_BITS/8 bytes,
// 512 by default, during which no item is taken; size resets to STORE_BITS
module bitmap_store_engine_unit import bse_pkg::*; #(
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  bse_in_if.sink            item,
  bse_out_if.source         result
);

  bse_cmd_t    cmd;
  bse_status_t st;

  bse_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg_we (cfg_we),
    .st     (st),
    .cmd    (cmd)
  );

  bse_datapath #(
    .STORE_BITS (STORE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== verif/bitmap_result_checker.sv =====
`timescale 1ns / 1ps

module bitmap_result_checker import bse_pkg::*; #(
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  bse_in_if                 item_mon,
  bse_out_if                result_mon,
  output int                fail_count,
  output int                pending
);

  localparam int STORE_BYTES = (STORE_BITS + 7) / 8;

  typedef struct packed {
    logic [DATA_W-1:0]   data_byte;
    logic                flag;
    logic [FILLED_W-1:0] bytes_filled;
    logic                last;
  } result_word_t;

  // shadow copy of the bitmap and its configured size
  logic [7:0]   bitmap [STORE_BYTES];
  int           size_bits_q;
  result_word_t expected_words [$];
  int           mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t checker: %s", $time, what);
  endtask

  task automatic clear_bitmap();
    foreach (bitmap[k]) bitmap[k] = 8'h00;
  endtask

  // bits at or past the size read as zero
  function automatic logic stored_bit(input int b);
    if (b >= size_bits_q) return 1'b0;
    return bitmap[b >> 3][b & 7];
  endfunction

  task automatic put_bit(input int b, input logic v);
    if (b < size_bits_q) bitmap[b >> 3][b & 7] = v;
  endtask

  task automatic push_word(input logic [7:0] d, input logic flag, input int filled,
                           input logic last);
    result_word_t w;
    w.data_byte    = d;
    w.flag         = flag;
    w.bytes_filled = FILLED_W'(filled);
    w.last         = last;
    expected_words.push_back(w);
  endtask

  // expected words for one accepted item, updating the shadow bitmap
  task automatic predict_bitmap_op(input bse_op_t op, input int bidx, input logic bval,
                                   input int byidx, input int bycnt, input int bcnt);
    int         n, cap, want, bits, i, j;
    logic       flag;
    logic [7:0] d;
    flag = 1'b0;
    case (op)
      OP_SET:   put_bit(bidx, 1'b1);
      OP_CLEAR: put_bit(bidx, 1'b0);
      OP_WRITE: put_bit(bidx, bval);
      OP_TEST:  flag = stored_bit(bidx);
      OP_TAS: begin
        if (bidx < size_bits_q && !stored_bit(bidx)) begin
          put_bit(bidx, 1'b1);
          flag = 1'b1;
        end
      end
      OP_READ, OP_READ_NEG: begin
        cap  = (size_bits_q + 7) / 8;
        want = bycnt > MAX_RUN_BYTES ? MAX_RUN_BYTES : bycnt;
        n    = 0;
        if (byidx < cap) n = (cap - byidx) > want ? want : cap - byidx;
        if (n == 0) begin
          push_word(8'h00, 1'b0, 0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            d = bitmap[byidx + i];
            if (op == OP_READ_NEG) d = ~d;
            push_word(d, 1'b0, n, i == n - 1);
          end
        end
      end
      default: begin
        // negated bit run, packed lsb first, unused high bits zero
        want = bcnt > MAX_RUN_BYTES * 8 ? MAX_RUN_BYTES * 8 : bcnt;
        bits = 0;
        if (bidx < size_bits_q) bits = (size_bits_q - bidx) > want ? want : size_bits_q - bidx;
        n = (bits + 7) / 8;
        if (n == 0) begin
          push_word(8'h00, 1'b0, 0, 1'b1);
        end else begin
          for (i = 0; i < n; i++) begin
            d = 8'h00;
            for (j = 0; j < 8; j++) begin
              if (i * 8 + j < bits && !stored_bit(bidx + i * 8 + j)) d[j] = 1'b1;
            end
            push_word(d, 1'b0, n, i == n - 1);
          end
        end
      end
    endcase
    if (op <= OP_TAS) push_word(8'h00, flag, 0, 1'b1);
  endtask

  task automatic check_word(input logic [DATA_W-1:0] d, input logic flag,
                            input logic [FILLED_W-1:0] filled, input logic last);
    result_word_t exp_w;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word 0x%02h with nothing pending", d));
      return;
    end
    exp_w = expected_words.pop_front();
    if (d !== exp_w.data_byte)
      report_mismatch($sformatf("data_byte 0x%02h, wanted 0x%02h", d, exp_w.data_byte));
    if (flag !== exp_w.flag)
      report_mismatch($sformatf("flag %b, wanted %b", flag, exp_w.flag));
    if (filled !== exp_w.bytes_filled)
      report_mismatch($sformatf("bytes_filled %0d, wanted %0d", filled,
                                exp_w.bytes_filled));
    if (last !== exp_w.last)
      report_mismatch($sformatf("last %b, wanted %b", last, exp_w.last));
  endtask

  // watch config, input and result channels
  always @(posedge clk) begin
    if (rst) begin
      clear_bitmap();
      size_bits_q = STORE_BITS;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        size_bits_q = cfg_wdata > STORE_BITS ? STORE_BITS : int'(cfg_wdata);
        clear_bitmap();
      end
      if (item_mon.valid && item_mon.ready) begin
        predict_bitmap_op(bse_op_t'(item_mon.op), int'(item_mon.bit_index),
                          item_mon.bit_value, int'(item_mon.byte_index),
                          int'(item_mon.byte_count), int'(item_mon.bit_count));
      end
      if (result_mon.valid && result_mon.ready) begin
        check_word(result_mon.data_byte, result_mon.flag, result_mon.bytes_filled,
                   result_mon.last);
      end
    end
    pending    <= expected_words.size();
    fail_count <= mismatches;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bse_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  bse_in_if  item_if ();
  bse_out_if result_if ();

  int fail_count;
  int pending;
  int cycle_count = 0;
  int cur_size    = STORE_BITS_DEF;
  int stall_left  = 0;
  bit valid_burst = 1'b0;
  bit ready_burst = 1'b0;

  bitmap_store_engine_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  bitmap_result_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_mon   (item_if),
    .result_mon (result_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_store_engine_unit: mismatch");
      $finish;
    end
  end

  // result back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin : ready_gen
    int roll;
    roll = $urandom_range(0, 99);
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      result_if.ready <= 1'b0;
    end else if (ready_burst || roll < 60) begin
      result_if.ready <= 1'b1;
    end else if (roll < 92) begin
      result_if.ready <= 1'b0;
      stall_left      <= $urandom_range(0, 2);
    end else begin
      result_if.ready <= 1'b0;
      stall_left      <= $urandom_range(8, 30);
    end
  end

  function automatic int pick_gap();
    int roll;
    if (valid_burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input word, held until accepted
  task automatic issue_item(input bse_op_t op, input int bidx, input int bval,
                            input int byidx, input int bycnt, input int bcnt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.op         <= op;
    item_if.bit_index  <= BIT_IDX_W'(bidx);
    item_if.bit_value  <= bval[0];
    item_if.byte_index <= BYTE_IDX_W'(byidx);
    item_if.byte_count <= BYTE_CNT_W'(bycnt);
    item_if.bit_count  <= BIT_CNT_W'(bcnt);
    item_if.valid      <= 1'b1;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  // size change only once the engine has drained
  task automatic write_size(input int v);
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= SIZE_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size = v > STORE_BITS_DEF ? STORE_BITS_DEF : v;
  endtask

  // random word aimed at the low region that gets written and at the size edge
  task automatic random_item();
    int      roll, hot_bits, bytes_used, lo, hi;
    int      bidx, byidx, bycnt, bcnt;
    bse_op_t op;
    hot_bits   = cur_size + 8 < 128 ? cur_size + 8 : 128;
    bytes_used = (cur_size + 7) / 8;
    roll = $urandom_range(0, 99);
    if (roll < 12)      op = OP_SET;
    else if (roll < 20) op = OP_CLEAR;
    else if (roll < 32) op = OP_WRITE;
    else if (roll < 42) op = OP_TEST;
    else if (roll < 54) op = OP_TAS;
    else if (roll < 68) op = OP_READ;
    else if (roll < 80) op = OP_READ_NEG;
    else                op = OP_EXTRACT;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      bidx = $urandom_range(0, hot_bits - 1);
    end else if (roll < 80) begin
      lo   = cur_size > 10 ? cur_size - 10 : 0;
      hi   = cur_size + 6 < 4095 ? cur_size + 6 : 4095;
      bidx = $urandom_range(lo, hi);
    end else begin
      bidx = $urandom_range(0, 4095);
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      byidx = $urandom_range(0, (hot_bits - 1) / 8);
    end else if (roll < 80) begin
      lo    = bytes_used > 3 ? bytes_used - 3 : 0;
      hi    = bytes_used + 2 < 511 ? bytes_used + 2 : 511;
      byidx = $urandom_range(lo, hi);
    end else begin
      byidx = $urandom_range(0, 511);
    end
    bycnt = $urandom_range(0, 99) < 85 ? $urandom_range(0, 8) : $urandom_range(9, 15);
    bcnt  = $urandom_range(0, 99) < 85 ? $urandom_range(0, 64) : $urandom_range(65, 127);
    issue_item(op, bidx, $urandom_range(0, 1), byidx, bycnt, bcnt);
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        valid_burst  = $urandom_range(0, 3) == 0;
        ready_burst <= $urandom_range(0, 3) == 0;
      end
      random_item();
    end
  endtask

  // stimulus and verdict
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    item_if.valid      <= 1'b0;
    item_if.op         <= '0;
    item_if.bit_index  <= '0;
    item_if.bit_value  <= 1'b0;
    item_if.byte_index <= '0;
    item_if.byte_count <= '0;
    item_if.bit_count  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // full size: bit ops at both ends, runs clipped and empty
    issue_item(OP_TEST,     0,    0, 0,   0,  0);
    issue_item(OP_TAS,      0,    0, 0,   0,  0);
    issue_item(OP_TAS,      0,    0, 0,   0,  0);
    issue_item(OP_TEST,     0,    0, 0,   0,  0);
    issue_item(OP_SET,      4095, 0, 0,   0,  0);
    issue_item(OP_TEST,     4095, 0, 0,   0,  0);
    issue_item(OP_WRITE,    7,    1, 0,   0,  0);
    issue_item(OP_WRITE,    9,    1, 0,   0,  0);
    issue_item(OP_WRITE,    7,    0, 0,   0,  0);
    issue_item(OP_SET,      8,    0, 0,   0,  0);
    issue_item(OP_CLEAR,    0,    0, 0,   0,  0);
    issue_item(OP_READ,     0,    0, 0,   8,  0);
    issue_item(OP_READ_NEG, 0,    0, 0,   15, 0);
    issue_item(OP_READ,     0,    0, 511, 8,  0);
    issue_item(OP_READ,     0,    0, 5,   0,  0);
    issue_item(OP_READ_NEG, 0,    0, 511, 15, 0);
    issue_item(OP_EXTRACT,  1,    0, 0,   0,  64);
    issue_item(OP_EXTRACT,  4090, 0, 0,   0,  127);
    issue_item(OP_EXTRACT,  3,    0, 0,   0,  13);
    issue_item(OP_EXTRACT,  0,    0, 0,   0,  0);
    random_run(80);

    // empty store: everything ignored or empty
    write_size(0);
    issue_item(OP_SET,     0, 0, 0, 0, 0);
    issue_item(OP_TEST,    0, 0, 0, 0, 0);
    issue_item(OP_READ,    0, 0, 0, 8, 0);
    issue_item(OP_EXTRACT, 0, 0, 0, 0, 8);
    random_run(15);

    // partial last byte: bits past the size
    write_size(13);
    issue_item(OP_SET,      12, 0, 0, 0, 0);
    issue_item(OP_SET,      13, 0, 0, 0, 0);
    issue_item(OP_TEST,     13, 0, 0, 0, 0);
    issue_item(OP_TAS,      13, 0, 0, 0, 0);
    issue_item(OP_READ_NEG, 0,  0, 0, 8, 0);
    issue_item(OP_READ,     0,  0, 2, 1, 0);
    issue_item(OP_EXTRACT,  10, 0, 0, 0, 64);
    issue_item(OP_EXTRACT,  13, 0, 0, 0, 5);
    random_run(50);

    write_size(1);
    random_run(20);
    // oversized value saturates to the full store
    write_size(8191);
    random_run(60);
    write_size($urandom_range(1, 4095));
    random_run(70);
    write_size(4096);
    random_run(70);
    write_size(100);
    random_run(35);

    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bitmap_store_engine_unit: match");
    end else begin
      $display("bitmap_store_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
